FILE: rtl/lcdtc_pkg.sv
// ----------------------------------------------------------------------------
// LCD text controller package
// Shared types, character codes, command bytes and lookup functions for the
// character LCD text and cursor controller.
// ----------------------------------------------------------------------------
package lcdtc_pkg;

  // Control characters that get special handling.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Display commands.
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  // Result status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_ROW = 2'd1;
  localparam logic [1:0] STATUS_NO_COL = 2'd2;

  // Request types.
  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_INIT = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [1:0] CFG_TAB_SIZE     = 2'd2;

  // Display geometry limits.
  localparam logic [2:0] MAX_ROWS = 3'd4;
  localparam logic [5:0] MAX_COLS = 6'd40;

  // Index of the final byte of the setup sequence.
  localparam logic [2:0] INIT_LAST = 3'd6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_EXEC,
    ST_INIT,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic exec;
    logic init_load;
    logic init_next;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_init;
    logic is_tab;
    logic div_last;
    logic init_last;
  } ctrl_sts_t;

  // DDRAM base address command for each row.
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      2'd3:    base = 8'hD4;
      default: base = 8'h80;
    endcase
    return base;
  endfunction

  // 4-bit mode setup sequence.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h08;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      3'd6:    b = 8'h0C;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/lcdtc_in_if.sv
// ----------------------------------------------------------------------------
// LCD text controller request channel
// Valid/ready channel carrying one text or initialization request per beat.
// ----------------------------------------------------------------------------
interface lcdtc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

FILE: rtl/lcdtc_out_if.sv
// ----------------------------------------------------------------------------
// LCD text controller result channel
// Valid/ready channel carrying one display bus write or status per beat.
// ----------------------------------------------------------------------------
interface lcdtc_out_if;
  logic       valid;
  logic       ready;
  logic       bus_write;
  logic       register_select;
  logic [7:0] bus_byte;
  logic [1:0] status_code;
  logic       last_of_run;

  modport source (
    output valid, output bus_write, output register_select, output bus_byte,
    output status_code, output last_of_run, input ready
  );
  modport sink (
    input valid, input bus_write, input register_select, input bus_byte,
    input status_code, input last_of_run, output ready
  );
endinterface

FILE: rtl/lcdtc_ctrl.sv
// ----------------------------------------------------------------------------
// LCD text controller sequencer
// State machine that steps the datapath through one request at a time and
// drives the handshakes of both channels.
// ----------------------------------------------------------------------------
module lcdtc_ctrl
  import lcdtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_init) begin
          state_nxt = ST_INIT;
        end else if (sts.is_tab) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_DIV: begin
        // One remainder bit per cycle for the tab stop.
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_INIT: begin
        cmd.init_load = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.is_init && !sts.init_last) begin
            cmd.init_next = 1'b1;
            state_nxt     = ST_INIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lcdtc_dp.sv
// ----------------------------------------------------------------------------
// LCD text controller datapath
// Holds the configuration, the cursor, the current request, a bit-serial
// remainder unit for tab stops and the result register.
// ----------------------------------------------------------------------------
module lcdtc_dp
  import lcdtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata,
  input  logic       in_req_type,
  input  logic [7:0] in_char_code,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  output logic       out_bus_write,
  output logic       out_register_select,
  output logic [7:0] out_bus_byte,
  output logic [1:0] out_status_code,
  output logic       out_last_of_run
);

  // Configuration registers.
  logic [2:0] row_count_r;
  logic [5:0] column_count_r;
  logic [4:0] tab_size_r;

  // Cursor and current request.
  logic [1:0] cur_row_r, cur_row_nxt;
  logic [5:0] cur_col_r, cur_col_nxt;
  logic       item_req_r;
  logic [7:0] item_char_r;
  logic [2:0] init_idx_r, init_idx_nxt;

  // Remainder unit.
  logic [5:0] rem_r, rem_nxt;
  logic [2:0] bit_idx_r, bit_idx_nxt;

  // Result register.
  logic       res_wr_r, res_wr_nxt;
  logic       res_rs_r, res_rs_nxt;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic       res_last_r, res_last_nxt;

  // Effective limits and per-request values.
  logic [2:0] rows_eff;
  logic [5:0] cols_eff;
  logic [4:0] ts_eff;
  logic [5:0] rem_sh;
  logic [6:0] tab_target;
  logic [1:0] ex_row;
  logic [5:0] ex_col;
  logic       ex_addr;
  logic       ex_wr;
  logic       ex_rs;
  logic [7:0] ex_byte;
  logic [1:0] ex_status;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 3'd2;
      column_count_r <= 6'd16;
      tab_size_r     <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_wdata[2:0];
        CFG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        CFG_TAB_SIZE:     tab_size_r     <= cfg_wdata[4:0];
        default:          ;
      endcase
    end
  end

  // Clamp the limits to what the display supports.
  always_comb begin
    if (row_count_r == 3'd0) begin
      rows_eff = 3'd1;
    end else if (row_count_r > MAX_ROWS) begin
      rows_eff = MAX_ROWS;
    end else begin
      rows_eff = row_count_r;
    end
    cols_eff = (column_count_r > MAX_COLS) ? MAX_COLS : column_count_r;
    ts_eff   = (tab_size_r == 5'd0) ? 5'd1 : tab_size_r;
  end

  // Restoring remainder step: shift in one cursor bit and reduce.
  always_comb begin
    rem_sh = {rem_r[4:0], cur_col_r[bit_idx_r]};
    if (rem_sh >= {1'b0, ts_eff}) begin
      rem_sh = rem_sh - {1'b0, ts_eff};
    end
  end

  // Next tab stop: strictly past the cursor on a multiple of the tab size.
  assign tab_target = {1'b0, cur_col_r} + {2'b00, ts_eff} - {1'b0, rem_r};

  // Result and cursor update for a text request.
  always_comb begin
    ex_row    = cur_row_r;
    ex_col    = cur_col_r;
    ex_addr   = 1'b0;
    ex_wr     = 1'b0;
    ex_rs     = 1'b0;
    ex_byte   = 8'h00;
    ex_status = STATUS_OK;
    case (item_char_r)
      CH_FF: begin
        ex_wr   = 1'b1;
        ex_byte = CMD_CLEAR;
        ex_row  = 2'd0;
        ex_col  = 6'd0;
      end
      CH_LF: begin
        if (({1'b0, cur_row_r} + 3'd1) < rows_eff) begin
          ex_row  = cur_row_r + 2'd1;
          ex_addr = 1'b1;
        end else begin
          ex_status = STATUS_NO_ROW;
        end
      end
      CH_CR: begin
        ex_col  = 6'd0;
        ex_addr = 1'b1;
      end
      CH_TAB: begin
        if (tab_target < {1'b0, cols_eff}) begin
          ex_col  = tab_target[5:0];
          ex_addr = 1'b1;
        end else begin
          ex_status = STATUS_NO_COL;
        end
      end
      default: begin
        if (cur_col_r < cols_eff) begin
          ex_wr   = 1'b1;
          ex_rs   = 1'b1;
          ex_byte = item_char_r;
          ex_col  = cur_col_r + 6'd1;
        end else begin
          ex_status = STATUS_NO_COL;
        end
      end
    endcase
    // Cursor moves are followed by a set-address command.
    if (ex_addr) begin
      ex_wr   = 1'b1;
      ex_byte = row_base(ex_row) + {2'b00, ex_col};
    end
  end

  // Next values of the working registers.
  always_comb begin
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    init_idx_nxt   = init_idx_r;
    rem_nxt        = rem_r;
    bit_idx_nxt    = bit_idx_r;
    res_wr_nxt     = res_wr_r;
    res_rs_nxt     = res_rs_r;
    res_byte_nxt   = res_byte_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    if (cmd.load) begin
      init_idx_nxt = 3'd0;
      rem_nxt      = 6'd0;
      bit_idx_nxt  = 3'd5;
      if (in_req_type == REQ_INIT) begin
        cur_row_nxt = 2'd0;
        cur_col_nxt = 6'd0;
      end
    end
    if (cmd.div_step) begin
      rem_nxt     = rem_sh;
      bit_idx_nxt = bit_idx_r - 3'd1;
    end
    if (cmd.exec) begin
      cur_row_nxt    = ex_row;
      cur_col_nxt    = ex_col;
      res_wr_nxt     = ex_wr;
      res_rs_nxt     = ex_rs;
      res_byte_nxt   = ex_byte;
      res_status_nxt = ex_status;
      res_last_nxt   = 1'b1;
    end
    if (cmd.init_load) begin
      res_wr_nxt     = 1'b1;
      res_rs_nxt     = 1'b0;
      res_byte_nxt   = init_byte(init_idx_r);
      res_status_nxt = STATUS_OK;
      res_last_nxt   = (init_idx_r == INIT_LAST);
    end
    if (cmd.init_next) begin
      init_idx_nxt = init_idx_r + 3'd1;
    end
  end

  // Cursor holds control state and is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= 2'd0;
      cur_col_r <= 6'd0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_req_r  <= in_req_type;
      item_char_r <= in_char_code;
    end
    init_idx_r   <= init_idx_nxt;
    rem_r        <= rem_nxt;
    bit_idx_r    <= bit_idx_nxt;
    res_wr_r     <= res_wr_nxt;
    res_rs_r     <= res_rs_nxt;
    res_byte_r   <= res_byte_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
  end

  // Status to the sequencer.
  assign sts.is_init   = (item_req_r == REQ_INIT);
  assign sts.is_tab    = (item_char_r == CH_TAB);
  assign sts.div_last  = (bit_idx_r == 3'd0);
  assign sts.init_last = (init_idx_r == INIT_LAST);

  assign out_bus_write       = res_wr_r;
  assign out_register_select = res_rs_r;
  assign out_bus_byte        = res_byte_r;
  assign out_status_code     = res_status_r;
  assign out_last_of_run     = res_last_r;

endmodule

FILE: rtl/char_lcd_text_cursor_controller.sv
// ----------------------------------------------------------------------------
// Character LCD text and cursor controller
// Converts text bytes into HD44780-style command and data writes.
// ----------------------------------------------------------------------------
// One request is handled at a time. A text byte passes through accept, decode,
// execute and present states before its result is offered, and a tab also
// passes a remainder state while a one-bit-per-cycle remainder unit finds the
// next tab stop. An initialization request produces seven command beats, each
// loaded in the init state and offered in the output state. The next request is
// accepted in the cycle after the last result of a request is taken. The
// cursor is checked against the limits in force when a byte is executed; set
// row_count, column_count and tab_size only while the block is idle.
module char_lcd_text_cursor_controller
  import lcdtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  lcdtc_in_if.sink    in_ch,
  lcdtc_out_if.source out_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  lcdtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  lcdtc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_req_type         (in_ch.req_type),
    .in_char_code        (in_ch.char_code),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_bus_write       (out_ch.bus_write),
    .out_register_select (out_ch.register_select),
    .out_bus_byte        (out_ch.bus_byte),
    .out_status_code     (out_ch.status_code),
    .out_last_of_run     (out_ch.last_of_run)
  );

endmodule

FILE: tb/char_lcd_text_cursor_controller_tb.sv
// ----------------------------------------------------------------------------
// Character LCD text and cursor controller testbench
// Drives text and setup requests through the request channel in random
// bursts, tracks the cursor and geometry registers on its own, and compares
// every display beat, field by field, with the expected beat in order.
// ----------------------------------------------------------------------------
module char_lcd_text_cursor_controller_tb;
  import lcdtc_pkg::*;

  // Register index with no register behind it.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Setup command bytes, first byte in the top lane.
  localparam logic [55:0] SETUP_BYTES = 56'h33_32_28_08_01_06_0C;
  // DDRAM base address per row, row 0 in the top lane.
  localparam logic [31:0] ROW_BASES = 32'h80_C0_94_D4;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE
  } stall_mode_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } text_req_t;

  typedef struct packed {
    logic       bus_write;
    logic       register_select;
    logic [7:0] bus_byte;
    logic [1:0] status_code;
    logic       last_of_run;
  } lcd_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_wdata = '0;

  lcdtc_in_if  in_ch ();
  lcdtc_out_if out_ch ();

  char_lcd_text_cursor_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Requests waiting to be sent and display beats still owed by the block.
  text_req_t   requests_pending[$];
  lcd_beat_t   lcd_writes_due[$];
  int          error_count = 0;

  // Own copy of the registers and the cursor.
  logic [2:0]  rows_reg = 3'd2;
  logic [5:0]  cols_reg = 6'd16;
  logic [4:0]  tab_reg = 5'd4;
  logic [1:0]  cursor_row = '0;
  logic [5:0]  cursor_col = '0;

  // Sender burst and gap counters.
  int          burst_left = 0;
  int          gap_left = 0;
  text_req_t   next_req;

  // Receiver stall pattern state.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  logic [1:0]  stall_tick = '0;
  lcd_beat_t   seen_beat;
  lcd_beat_t   due_beat;

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_TEXT;
    in_ch.char_code = '0;
    out_ch.ready    = 1'b0;
  end

  // Clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void owe_beat(input logic wr, input logic rs, input logic [7:0] data,
                                   input logic [1:0] status, input logic last);
    lcd_beat_t b;
    b.bus_write       = wr;
    b.register_select = rs;
    b.bus_byte        = data;
    b.status_code     = status;
    b.last_of_run     = last;
    lcd_writes_due.push_back(b);
  endfunction

  // Works out the display beats of one accepted request and moves the cursor.
  function automatic void track_cursor(input text_req_t r);
    int         rows;
    int         cols;
    int         stop;
    int         target;
    logic       moved;
    logic [7:0] base;
    rows  = (rows_reg == 3'd0) ? 1 : (rows_reg > MAX_ROWS) ? int'(MAX_ROWS) : int'(rows_reg);
    cols  = (cols_reg > MAX_COLS) ? int'(MAX_COLS) : int'(cols_reg);
    stop  = (tab_reg == 5'd0) ? 1 : int'(tab_reg);
    moved = 1'b1;
    if (r.req_type == REQ_INIT) begin
      for (int k = 0; k <= INIT_LAST; k++)
        owe_beat(1'b1, 1'b0, SETUP_BYTES[8*(INIT_LAST-k) +: 8], STATUS_OK, k == INIT_LAST);
      cursor_row = '0;
      cursor_col = '0;
    end else if (r.char_code == CH_FF) begin
      owe_beat(1'b1, 1'b0, CMD_CLEAR, STATUS_OK, 1'b1);
      cursor_row = '0;
      cursor_col = '0;
    end else if (r.char_code == CH_LF || r.char_code == CH_CR || r.char_code == CH_TAB) begin
      if (r.char_code == CH_LF) begin
        if (cursor_row + 1 < rows) begin
          cursor_row = cursor_row + 2'd1;
        end else begin
          owe_beat(1'b0, 1'b0, 8'h00, STATUS_NO_ROW, 1'b1);
          moved = 1'b0;
        end
      end else if (r.char_code == CH_CR) begin
        cursor_col = '0;
      end else begin
        target = cursor_col + (stop - (cursor_col % stop));
        if (target < cols) begin
          cursor_col = target[5:0];
        end else begin
          owe_beat(1'b0, 1'b0, 8'h00, STATUS_NO_COL, 1'b1);
          moved = 1'b0;
        end
      end
      // A successful move is followed by a set-address command.
      if (moved) begin
        base = ROW_BASES[8*(3-cursor_row) +: 8];
        owe_beat(1'b1, 1'b0, base + {2'b00, cursor_col}, STATUS_OK, 1'b1);
      end
    end else if (cursor_col < cols) begin
      owe_beat(1'b1, 1'b1, r.char_code, STATUS_OK, 1'b1);
      cursor_col = cursor_col + 6'd1;
    end else begin
      owe_beat(1'b0, 1'b0, 8'h00, STATUS_NO_COL, 1'b1);
    end
  endfunction

  // Request driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        track_cursor('{req_type: in_ch.req_type, char_code: in_ch.char_code});
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (requests_pending.size() > 0) begin
          next_req = requests_pending.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.req_type  <= next_req.req_type;
          in_ch.char_code <= next_req.char_code;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_beat = '{bus_write: out_ch.bus_write, register_select: out_ch.register_select,
                      bus_byte: out_ch.bus_byte, status_code: out_ch.status_code,
                      last_of_run: out_ch.last_of_run};
        if (lcd_writes_due.size() == 0) begin
          $error("unexpected beat: bus_byte %0h status_code %0d",
                 seen_beat.bus_byte, seen_beat.status_code);
          error_count++;
        end else begin
          due_beat = lcd_writes_due.pop_front();
          if (seen_beat.bus_write !== due_beat.bus_write) begin
            $error("bus_write: expected %0d, actual %0d", due_beat.bus_write,
                   seen_beat.bus_write);
            error_count++;
          end
          if (seen_beat.register_select !== due_beat.register_select) begin
            $error("register_select: expected %0d, actual %0d", due_beat.register_select,
                   seen_beat.register_select);
            error_count++;
          end
          if (seen_beat.bus_byte !== due_beat.bus_byte) begin
            $error("bus_byte: expected %0h, actual %0h", due_beat.bus_byte,
                   seen_beat.bus_byte);
            error_count++;
          end
          if (seen_beat.status_code !== due_beat.status_code) begin
            $error("status_code: expected %0d, actual %0d", due_beat.status_code,
                   seen_beat.status_code);
            error_count++;
          end
          if (seen_beat.last_of_run !== due_beat.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", due_beat.last_of_run,
                   seen_beat.last_of_run);
            error_count++;
          end
        end
      end
      // Switch stall pattern when the mode counter runs out.
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 80);
      end else begin
        mode_left--;
      end
      stall_tick = stall_tick + 2'd1;
      case (stall_mode)
        STALL_NONE:   out_ch.ready <= 1'b1;
        STALL_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        default:      out_ch.ready <= (stall_tick == 2'd0);
      endcase
    end
  end

  function automatic void queue_req(input logic req, input logic [7:0] ch);
    requests_pending.push_back('{req_type: req, char_code: ch});
  endfunction

  // Mostly text with line control, plus occasional setup and arbitrary bytes.
  function automatic text_req_t random_request();
    text_req_t r;
    int        pick;
    pick        = $urandom_range(0, 99);
    r.req_type  = REQ_TEXT;
    r.char_code = 8'($urandom_range(32, 126));
    if (pick < 4) begin
      r.req_type  = REQ_INIT;
      r.char_code = 8'($urandom_range(0, 255));
    end else if (pick < 8) begin
      r.char_code = CH_FF;
    end else if (pick < 17) begin
      r.char_code = CH_LF;
    end else if (pick < 25) begin
      r.char_code = CH_CR;
    end else if (pick < 35) begin
      r.char_code = CH_TAB;
    end else if (pick >= 88) begin
      r.char_code = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROW_COUNT:    rows_reg = value[2:0];
      CFG_COLUMN_COUNT: cols_reg = value;
      CFG_TAB_SIZE:     tab_reg  = value[4:0];
      default:          ;
    endcase
  endtask

  task automatic set_geometry(input logic [2:0] rows, input logic [5:0] cols,
                              input logic [4:0] tab);
    write_reg(CFG_ROW_COUNT, {3'b000, rows});
    write_reg(CFG_COLUMN_COUNT, cols);
    write_reg(CFG_TAB_SIZE, {1'b0, tab});
  endtask

  // Block is idle once nothing is queued, offered or owed.
  task automatic wait_drained();
    @(negedge clk);
    while (requests_pending.size() != 0 || in_ch.valid || lcd_writes_due.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset geometry: setup, data extremes, line control.
    queue_req(REQ_INIT, 8'h00);
    queue_req(REQ_TEXT, 8'h41);
    queue_req(REQ_TEXT, 8'h00);
    queue_req(REQ_TEXT, 8'hFF);
    queue_req(REQ_TEXT, CH_TAB);
    queue_req(REQ_TEXT, CH_TAB);
    queue_req(REQ_TEXT, CH_LF);
    queue_req(REQ_TEXT, CH_LF);
    queue_req(REQ_TEXT, CH_CR);
    queue_req(REQ_TEXT, CH_FF);
    queue_req(REQ_INIT, 8'hFF);
    wait_drained();

    // Narrow, tall display: column full, tab past the end, last row reached.
    write_reg(CFG_SPARE, 6'h3F);
    set_geometry(3'd4, 6'd3, 5'd1);
    queue_req(REQ_TEXT, 8'h80);
    queue_req(REQ_TEXT, 8'h7F);
    queue_req(REQ_TEXT, 8'h55);
    queue_req(REQ_TEXT, 8'hAA);
    queue_req(REQ_TEXT, CH_TAB);
    queue_req(REQ_TEXT, CH_LF);
    queue_req(REQ_TEXT, CH_LF);
    queue_req(REQ_TEXT, CH_LF);
    queue_req(REQ_TEXT, CH_LF);
    queue_req(REQ_TEXT, CH_CR);
    queue_req(REQ_TEXT, CH_TAB);
    wait_drained();

    // Random phases, the first four at the register extremes.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       set_geometry(3'd1, 6'd40, 5'd16);
        1:       set_geometry(3'd4, 6'd1, 5'd1);
        2:       set_geometry(3'd0, 6'd0, 5'd0);
        3:       set_geometry(3'd7, 6'd63, 5'd31);
        default: set_geometry(3'($urandom_range(0, 7)),
                              ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                          : 6'($urandom_range(1, 40)),
                              5'($urandom_range(0, 31)));
      endcase
      repeat ($urandom_range(14, 22)) requests_pending.push_back(random_request());
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (error_count == 0 && lcd_writes_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 200000);
    $display("tb: failure");
    $finish;
  end

endmodule
